/* rtl/hsvrgb_pkg.sv */
// Shared types, constants and channel-order function for the HSV to RGB converter.
package hsvrgb_pkg;

	localparam int HUE_W       = 16;
	localparam int PCT_W       = 7;
	localparam int RGB_W       = 8;
	localparam int PROD_W      = 14;
	localparam int FRAC_W      = 10;
	localparam int NUM_W       = 24;
	localparam int SCALED_W    = 22;

	localparam int PCT_MAX       = 100;
	localparam int SECT_W        = 960;
	localparam int HUE_DIV15_K   = 1093;
	localparam int HUE_DIV15_SH  = 14;
	localparam int HUE_BIAS_REM  = 128;
	localparam int HUE_WRAP_ADD  = SECT_W - HUE_BIAS_REM;
	localparam int SIX_K         = 43;
	localparam int SIX_SH        = 8;
	localparam int CHAN_MUL      = 255;
	localparam int CHAN_SH       = 10;
	localparam int CHAN_DIV      = 9375;
	localparam int CHAN_RECIP_K  = 114532;
	localparam int CHAN_RECIP_SH = 30;

	typedef logic [2:0] sector_t;

	typedef enum logic [1:0] {
		TERM_ZERO,
		TERM_CHROMA,
		TERM_MID
	} term_t;

	typedef enum logic [1:0] {
		CH_RED,
		CH_GREEN,
		CH_BLUE
	} chan_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
	} stage_en_t;

	function automatic term_t chan_term(input sector_t idx, input chan_t ch);
		term_t t;
		t = TERM_ZERO;
		case (ch)
			CH_RED: begin
				case (idx)
					3'd0, 3'd5: t = TERM_CHROMA;
					3'd1, 3'd4: t = TERM_MID;
					default:    t = TERM_ZERO;
				endcase
			end
			CH_GREEN: begin
				case (idx)
					3'd1, 3'd2: t = TERM_CHROMA;
					3'd0, 3'd3: t = TERM_MID;
					default:    t = TERM_ZERO;
				endcase
			end
			CH_BLUE: begin
				case (idx)
					3'd3, 3'd4: t = TERM_CHROMA;
					3'd2, 3'd5: t = TERM_MID;
					default:    t = TERM_ZERO;
				endcase
			end
			default: t = TERM_ZERO;
		endcase
		return t;
	endfunction

endpackage

/* rtl/hsvrgb_if.sv */
// Valid/ready channel interfaces for HSV items in and RGB items out.
interface hsvrgb_hsv_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [hsvrgb_pkg::HUE_W-1:0] hue_sixteenths;
	logic        [hsvrgb_pkg::PCT_W-1:0] saturation_pct;
	logic        [hsvrgb_pkg::PCT_W-1:0] value_pct;

	modport source (output valid, hue_sixteenths, saturation_pct, value_pct, input ready);
	modport sink (input valid, hue_sixteenths, saturation_pct, value_pct, output ready);
endinterface

interface hsvrgb_rgb_if;
	logic                           valid;
	logic                           ready;
	logic [hsvrgb_pkg::RGB_W-1:0]  red;
	logic [hsvrgb_pkg::RGB_W-1:0]  green;
	logic [hsvrgb_pkg::RGB_W-1:0]  blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

/* rtl/hsvrgb_hue.sv */
// Hue decode: floored wrap into 0..360 degrees, 60-degree sector and in-sector ramp.
module hsvrgb_hue (
	input  logic                                 clk,
	input  hsvrgb_pkg::stage_en_t                en,
	input  logic signed [hsvrgb_pkg::HUE_W-1:0] hue,
	output hsvrgb_pkg::sector_t                  idx,
	output logic [hsvrgb_pkg::FRAC_W-1:0]        frac
);
	import hsvrgb_pkg::*;

	// s1: u = hue + 32768, a = floor(u / 960) via (u >> 6) / 15
	logic [HUE_W-1:0] u_s1_next;
	logic [20:0]      div_prod;
	logic [HUE_W-1:0] u_s1;
	logic [6:0]       a_s1;

	assign u_s1_next = {~hue[HUE_W-1], hue[HUE_W-2:0]};
	assign div_prod = 21'(u_s1_next[HUE_W-1:6]) * 21'(HUE_DIV15_K);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			u_s1 <= u_s1_next;
			a_s1 <= div_prod[HUE_DIV15_SH +: 7];
		end
	end

	// s2: remainder, bias correction, sector mod 6 and ramp
	logic [HUE_W-1:0]  sect_base;
	logic [HUE_W-1:0]  r_full;
	logic [FRAC_W-1:0] r;
	logic              lo;
	logic [FRAC_W-1:0] rem;
	logic [6:0]        x;
	logic [12:0]       six_prod;
	logic [6:0]        six_mul;
	sector_t           idx_next;
	sector_t           idx_s2;
	logic [FRAC_W-1:0] frac_s2;

	always_comb begin
		sect_base = 16'(a_s1) * 16'(SECT_W);
		r_full    = u_s1 - sect_base;
		r         = r_full[FRAC_W-1:0];
		lo        = r < FRAC_W'(HUE_BIAS_REM);
		rem       = lo ? r + FRAC_W'(HUE_WRAP_ADD) : r - FRAC_W'(HUE_BIAS_REM);
		x         = a_s1 + (lo ? 7'd1 : 7'd2);
		six_prod  = 13'(x) * 13'(SIX_K);
		six_mul   = 7'(six_prod[12:SIX_SH]) * 7'd6;
		idx_next  = 3'(x - six_mul);
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			idx_s2  <= idx_next;
			frac_s2 <= idx_next[0] ? FRAC_W'(SECT_W) - rem : rem;
		end
	end

	assign idx  = idx_s2;
	assign frac = frac_s2;

endmodule

/* rtl/hsvrgb_chan.sv */
// Channel scale: floor(n * 255 / 9600000) by shift, reciprocal multiply and one correction.
module hsvrgb_chan (
	input  logic                           clk,
	input  hsvrgb_pkg::stage_en_t          en,
	input  logic [hsvrgb_pkg::NUM_W-1:0]   num,
	output logic [hsvrgb_pkg::RGB_W-1:0]   q
);
	import hsvrgb_pkg::*;

	logic [31:0]         scale_prod;
	logic [SCALED_W-1:0] a_s5;
	logic [38:0]         recip_prod;
	logic [SCALED_W-1:0] a_s6;
	logic [RGB_W-1:0]    q0_s6;
	logic [SCALED_W-1:0] back;
	logic [SCALED_W-1:0] rem;
	logic [RGB_W-1:0]    q_s7;

	assign scale_prod = 32'(num) * 32'(CHAN_MUL);
	assign recip_prod = 39'(a_s5) * 39'(CHAN_RECIP_K);
	assign back       = 22'(q0_s6) * 22'(CHAN_DIV);
	assign rem        = a_s6 - back;

	always_ff @(posedge clk) begin
		if (en.s5) begin
			a_s5 <= scale_prod[31:CHAN_SH];
		end
		if (en.s6) begin
			a_s6  <= a_s5;
			q0_s6 <= recip_prod[CHAN_RECIP_SH +: RGB_W];
		end
		if (en.s7) begin
			q_s7 <= (rem >= SCALED_W'(CHAN_DIV)) ? q0_s6 + 8'd1 : q0_s6;
		end
	end

	assign q = q_s7;

endmodule

/* rtl/hsv_to_rgb_converter.sv */
// HSV to RGB converter top: seven-stage pipeline, one item per clock unless stalled.
// Takes a signed hue in 1/16 degree (wrapped modulo 360 degrees, floored), saturation and
// value in percent (clamped to 100) and returns 8-bit red, green and blue, each equal to
// floor((channel + m) * 255) computed exactly in integers. The depth is set by the hue
// decode (two stages), the chroma products (one), the channel mix (one) and the
// constant divide by 9600000 (three). A stall at the output holds only the stages that
// are full; empty stages keep filling, and the input is refused only when every stage
// holds an item.
module hsv_to_rgb_converter (
	input  logic         clk,
	input  logic         arst_n,
	hsvrgb_hsv_if.sink   hsv,
	hsvrgb_rgb_if.source rgb
);
	import hsvrgb_pkg::*;

	stage_en_t en;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;

	always_comb begin
		en.s7 = !valid_s7 || rgb.ready;
		en.s6 = !valid_s6 || en.s7;
		en.s5 = !valid_s5 || en.s6;
		en.s4 = !valid_s4 || en.s5;
		en.s3 = !valid_s3 || en.s4;
		en.s2 = !valid_s2 || en.s3;
		en.s1 = !valid_s1 || en.s2;
	end

	assign hsv.ready = en.s1;
	assign rgb.valid = valid_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= hsv.valid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
			if (en.s5) valid_s5 <= valid_s4;
			if (en.s6) valid_s6 <= valid_s5;
			if (en.s7) valid_s7 <= valid_s6;
		end
	end

	// hue path, stages 1-2
	sector_t           idx_s2;
	logic [FRAC_W-1:0] frac_s2;

	hsvrgb_hue u_hue (
		.clk  (clk),
		.en   (en),
		.hue  (hsv.hue_sixteenths),
		.idx  (idx_s2),
		.frac (frac_s2)
	);

	// s1: clamp, s*v
	logic [PCT_W-1:0]  sat_c;
	logic [PCT_W-1:0]  val_c;
	logic [PROD_W-1:0] p_s1;
	logic [PCT_W-1:0]  v_s1;

	assign sat_c = (hsv.saturation_pct > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : hsv.saturation_pct;
	assign val_c = (hsv.value_pct > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : hsv.value_pct;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			p_s1 <= PROD_W'(sat_c) * PROD_W'(val_c);
			v_s1 <= val_c;
		end
	end

	// s2: m term = 100v - sv
	logic [PROD_W-1:0] p_s2;
	logic [PROD_W-1:0] base_s2;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			p_s2    <= p_s1;
			base_s2 <= PROD_W'(v_s1) * PROD_W'(PCT_MAX) - p_s1;
		end
	end

	// s3: numerators over 10000 * 960
	logic [NUM_W-1:0] pf_s3;
	logic [NUM_W-1:0] pw_s3;
	logic [NUM_W-1:0] bw_s3;
	sector_t          idx_s3;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			pf_s3  <= NUM_W'(p_s2) * NUM_W'(frac_s2);
			pw_s3  <= NUM_W'(p_s2) * NUM_W'(SECT_W);
			bw_s3  <= NUM_W'(base_s2) * NUM_W'(SECT_W);
			idx_s3 <= idx_s2;
		end
	end

	// s4: per-channel mix, then stages 5-7 in the scalers
	logic [NUM_W-1:0] num_s4 [3];
	logic [NUM_W-1:0] term_val [3];
	logic [RGB_W-1:0] chan_q [3];

	for (genvar c = 0; c < 3; c++) begin : g_chan
		always_comb begin
			case (chan_term(idx_s3, chan_t'(c)))
				TERM_CHROMA: term_val[c] = pw_s3;
				TERM_MID:    term_val[c] = pf_s3;
				default:     term_val[c] = '0;
			endcase
		end

		always_ff @(posedge clk) begin
			if (en.s4) begin
				num_s4[c] <= bw_s3 + term_val[c];
			end
		end

		hsvrgb_chan u_chan (
			.clk (clk),
			.en  (en),
			.num (num_s4[c]),
			.q   (chan_q[c])
		);
	end

	assign rgb.red   = chan_q[CH_RED];
	assign rgb.green = chan_q[CH_GREEN];
	assign rgb.blue  = chan_q[CH_BLUE];

`ifndef SYNTHESIS
	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (idx_s2 <= 3'd5))
		else $error("hue sector out of range");

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (frac_s2 <= FRAC_W'(SECT_W)))
		else $error("hue ramp beyond sector width");

	a_mid_le_chroma: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (pf_s3 <= pw_s3))
		else $error("mid term exceeds chroma");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5 && valid_s6 && valid_s7
			&& !rgb.ready) |-> !hsv.ready)
		else $error("full pipeline accepted an item under stall");
`endif

endmodule

/* bench/hsv_to_rgb_converter_tb.sv */
// Self-checking testbench for the HSV to RGB converter: directed table, random items, stalls.
module hsv_to_rgb_converter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hsvrgb_pkg::*;

	localparam int     RAND_ITEMS  = 1027;
	localparam int     LONG_HOLD   = 60;
	localparam int     HOLD_AT     = 300;
	localparam int     DRAIN_WAIT  = 20;
	localparam int     CYCLE_LIMIT = 400000;
	localparam longint HUE_TURN    = 6 * SECT_W;
	localparam longint CHAN_DEN    = 10000 * SECT_W;

	typedef struct packed {
		logic [RGB_W-1:0] red;
		logic [RGB_W-1:0] green;
		logic [RGB_W-1:0] blue;
	} rgb_px_t;

	typedef struct packed {
		logic signed [HUE_W-1:0] hue;
		logic [PCT_W-1:0]        sat;
		logic [PCT_W-1:0]        val;
		logic                    typed;
		rgb_px_t                 px;
	} hsv_row_t;

	localparam int NUM_ROWS = 23;

	// typed rows carry the expected color; the rest go through the predictor
	hsv_row_t color_rows [NUM_ROWS] = '{
		'{16'sd0,      7'd100, 7'd100, 1'b1, '{8'd255, 8'd0,   8'd0}},
		'{16'sd960,    7'd100, 7'd100, 1'b1, '{8'd255, 8'd255, 8'd0}},
		'{16'sd1920,   7'd100, 7'd100, 1'b1, '{8'd0,   8'd255, 8'd0}},
		'{16'sd2880,   7'd100, 7'd100, 1'b1, '{8'd0,   8'd255, 8'd255}},
		'{16'sd3840,   7'd100, 7'd100, 1'b1, '{8'd0,   8'd0,   8'd255}},
		'{16'sd4800,   7'd100, 7'd100, 1'b1, '{8'd255, 8'd0,   8'd255}},
		'{16'sd5760,   7'd100, 7'd100, 1'b1, '{8'd255, 8'd0,   8'd0}},
		'{-16'sd5760,  7'd100, 7'd100, 1'b1, '{8'd255, 8'd0,   8'd0}},
		'{-16'sd960,   7'd100, 7'd100, 1'b1, '{8'd255, 8'd0,   8'd255}},
		'{16'sd480,    7'd100, 7'd100, 1'b1, '{8'd255, 8'd127, 8'd0}},
		'{16'sd0,      7'd100, 7'd50,  1'b1, '{8'd127, 8'd0,   8'd0}},
		'{16'sd0,      7'd0,   7'd100, 1'b1, '{8'd255, 8'd255, 8'd255}},
		'{16'sd1234,   7'd0,   7'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
		'{16'sd1920,   7'd127, 7'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
		'{-16'sd1,     7'd100, 7'd100, 1'b0, '0},
		'{-16'sd32768, 7'd100, 7'd100, 1'b0, '0},
		'{16'sd32767,  7'd100, 7'd100, 1'b0, '0},
		'{16'sd959,    7'd100, 7'd100, 1'b0, '0},
		'{16'sd777,    7'd127, 7'd127, 1'b0, '0},
		'{16'sd777,    7'd100, 7'd100, 1'b0, '0},
		'{16'sd777,    7'd101, 7'd50,  1'b0, '0},
		'{16'sd3000,   7'd50,  7'd127, 1'b0, '0},
		'{16'sd5000,   7'd37,  7'd81,  1'b0, '0}
	};

	logic clk;
	logic arst_n;

	hsvrgb_hsv_if hsv ();
	hsvrgb_rgb_if rgb ();

	hsv_to_rgb_converter DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.hsv    (hsv.sink),
		.rgb    (rgb.source)
	);

	rgb_px_t pending_colors [$];
	int      fail_count;
	int      colors_checked;
	int      pixels_sent;
	int      cycle_count = 0;
	bit      rx_holding = 1'b0;
	bit      long_hold_done = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic rgb_px_t predict_color(input logic signed [HUE_W-1:0] hue,
			input logic [PCT_W-1:0] sat_in, input logic [PCT_W-1:0] val_in);
		longint  h, hw, sect, rem, frac, s, v, cn, xn, mn, r, g, b;
		rgb_px_t px;
		h = hue;
		s = (sat_in > PCT_MAX) ? PCT_MAX : sat_in;
		v = (val_in > PCT_MAX) ? PCT_MAX : val_in;
		hw = h % HUE_TURN;
		if (hw < 0)
			hw += HUE_TURN;
		sect = hw / SECT_W;
		rem  = hw % SECT_W;
		frac = sect[0] ? SECT_W - rem : rem;
		cn = s * v * SECT_W;
		xn = s * v * frac;
		mn = (PCT_MAX * v - s * v) * SECT_W;
		case (sect)
			0: begin r = cn; g = xn; b = 0;  end
			1: begin r = xn; g = cn; b = 0;  end
			2: begin r = 0;  g = cn; b = xn; end
			3: begin r = 0;  g = xn; b = cn; end
			4: begin r = xn; g = 0;  b = cn; end
			default: begin r = cn; g = 0; b = xn; end
		endcase
		px.red   = RGB_W'(((r + mn) * CHAN_MUL) / CHAN_DEN);
		px.green = RGB_W'(((g + mn) * CHAN_MUL) / CHAN_DEN);
		px.blue  = RGB_W'(((b + mn) * CHAN_MUL) / CHAN_DEN);
		return px;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic note_failure(input string what);
		fail_count++;
		if (fail_count <= 10)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// drives one pixel and waits for it to be taken; expectation queued on acceptance
	task automatic send_pixel(input logic signed [HUE_W-1:0] hue, input logic [PCT_W-1:0] sat,
			input logic [PCT_W-1:0] val, input bit typed, input rgb_px_t typed_px);
		int      gap;
		rgb_px_t exp_px;
		gap = rx_holding ? 0 : pick_gap();
		if (gap > 0) begin
			hsv.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		hsv.valid          <= 1'b1;
		hsv.hue_sixteenths <= hue;
		hsv.saturation_pct <= sat;
		hsv.value_pct      <= val;
		do
			@(negedge clk);
		while (!hsv.ready);
		exp_px = typed ? typed_px : predict_color(hue, sat, val);
		pending_colors = {pending_colors, exp_px};
		pixels_sent++;
		@(posedge clk);
	endtask

	// output side: ready pattern with one long hold-off to back the pipeline up
	initial begin
		int stall;
		int run;
		rgb.ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (!long_hold_done && pixels_sent >= HOLD_AT) begin
				rx_holding = 1'b1;
				rgb.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold_done = 1'b1;
				rx_holding = 1'b0;
			end else begin
				stall = pick_gap();
				if (stall > 0) begin
					rgb.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				rgb.ready <= 1'b1;
				run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
				repeat (run) @(posedge clk);
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n && rgb.valid && rgb.ready) begin
			colors_checked++;
			if (pending_colors.size() == 0) begin
				note_failure($sformatf("unexpected item r=%0d g=%0d b=%0d",
					rgb.red, rgb.green, rgb.blue));
			end else if (pending_colors[0].red !== rgb.red
					|| pending_colors[0].green !== rgb.green
					|| pending_colors[0].blue !== rgb.blue) begin
				note_failure($sformatf("exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
					pending_colors[0].red, pending_colors[0].green, pending_colors[0].blue,
					rgb.red, rgb.green, rgb.blue));
				void'(pending_colors.pop_front());
			end else begin
				void'(pending_colors.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout with %0d items outstanding", pending_colors.size());
			$display("FAIL hsv_to_rgb_converter");
			$finish;
		end
	end

	initial begin
		logic signed [HUE_W-1:0] hue;
		logic [PCT_W-1:0]        sat;
		logic [PCT_W-1:0]        val;
		int                      pick;
		fail_count         = 0;
		colors_checked     = 0;
		pixels_sent        = 0;
		arst_n             = 1'b0;
		hsv.valid          = 1'b0;
		hsv.hue_sixteenths = '0;
		hsv.saturation_pct = '0;
		hsv.value_pct      = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_ROWS; i++) begin
			send_pixel(color_rows[i].hue, color_rows[i].sat, color_rows[i].val,
				color_rows[i].typed, color_rows[i].px);
		end

		for (int i = 0; i < RAND_ITEMS; i++) begin
			pick = $urandom_range(0, 9);
			if (pick < 3)
				hue = HUE_W'((int'($urandom_range(0, 68)) - 34) * SECT_W
					+ int'($urandom_range(0, 2)) - 1);
			else
				hue = HUE_W'($urandom);
			sat = ($urandom_range(0, 99) < 85) ? PCT_W'($urandom_range(0, 100))
				: PCT_W'($urandom_range(0, 127));
			val = ($urandom_range(0, 99) < 85) ? PCT_W'($urandom_range(0, 100))
				: PCT_W'($urandom_range(0, 127));
			send_pixel(hue, sat, val, 1'b0, '0);
		end
		hsv.valid <= 1'b0;

		while (pending_colors.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("%0d directed and %0d random pixels sent, %0d colors checked",
			NUM_ROWS, RAND_ITEMS, colors_checked);
		$display("output held off for %0d cycles once with input pushing; %0d failures",
			LONG_HOLD, fail_count);
		if (fail_count == 0 && pending_colors.size() == 0) begin
			$display("PASS hsv_to_rgb_converter");
		end else begin
			$display("FAIL hsv_to_rgb_converter");
		end
		$finish;
	end

endmodule
